// ===== rtl/core/mfep_pkg.sv =====
// Package for the MIDI track event parser.
// Holds parse phase, event kind, status and meta type codes, the event struct and the meta packing table.
// No dependencies.
package mfep_pkg;

  // Parse phases
  localparam logic [3:0] PH_DELTA     = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_DATA1     = 4'd2;
  localparam logic [3:0] PH_DATA2     = 4'd3;
  localparam logic [3:0] PH_META_TYPE = 4'd4;
  localparam logic [3:0] PH_META_LEN  = 4'd5;
  localparam logic [3:0] PH_META_BODY = 4'd6;
  localparam logic [3:0] PH_SYX_LEN   = 4'd7;
  localparam logic [3:0] PH_SYX_BODY  = 4'd8;

  // Event kinds
  localparam logic [3:0] KIND_NOTE_OFF   = 4'd0;
  localparam logic [3:0] KIND_NOTE_ON    = 4'd1;
  localparam logic [3:0] KIND_KEY_PRESS  = 4'd2;
  localparam logic [3:0] KIND_CONTROL    = 4'd3;
  localparam logic [3:0] KIND_PROGRAM    = 4'd4;
  localparam logic [3:0] KIND_CHAN_PRESS = 4'd5;
  localparam logic [3:0] KIND_PITCH      = 4'd6;
  localparam logic [3:0] KIND_META       = 4'd7;
  localparam logic [3:0] KIND_SYSEX      = 4'd8;
  localparam logic [3:0] KIND_INVALID    = 4'd9;

  // Status nibbles and special status bytes
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_KEY_PRESS  = 4'hA;
  localparam logic [3:0] HI_CONTROL    = 4'hB;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
  localparam logic [3:0] HI_PITCH      = 4'hE;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;
  localparam logic [7:0] STATUS_META   = 8'hFF;

  // Meta types
  localparam logic [7:0] META_SEQ_NUM   = 8'h00;
  localparam logic [7:0] META_CHAN_PFX  = 8'h20;
  localparam logic [7:0] META_END_TRACK = 8'h2F;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_SMPTE     = 8'h54;
  localparam logic [7:0] META_TIME_SIG  = 8'h58;
  localparam logic [7:0] META_KEY_SIG   = 8'h59;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  channel;
    logic [27:0] delta;
    logic [7:0]  p1;
    logic [31:0] p2;
    logic [27:0] blen;
    logic [13:0] pitch;
  } evt_t;

  // Payload bytes packed big-endian for a meta type
  function automatic logic [2:0] pack_size(input logic [7:0] t);
    logic [2:0] n;
    case (t)
      META_TEMPO:    n = 3'd3;
      META_TIME_SIG: n = 3'd4;
      META_KEY_SIG:  n = 3'd2;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/midi_file_event_parser.sv =====
// Standard MIDI file track event parser, top level.
// Input register, parser core and result register. Depends on mfep_pkg,
// mfep_parser and mfep_out_reg.
//
// Usage:
//   Input channel: one track byte per beat on in_data_byte, with
//   in_track_start high on the first byte of a track (a delta byte).
//   Result channel: one decoded event per beat on the out_ ports, given on
//   the byte that completes an event; bytes inside an event give no beat.
//   Path: the byte that ends an event is held in the input register, decoded
//   by the parser core and loaded into the result register, raising out_valid.
//   Throughput: one byte per cycle while no result waits on out_ready; the
//   phase machine sits between the input and result registers.
//   Stall: while a result waits on out_ready, the next byte is held in the
//   input register and in_ready stays low until the waiting result is taken.
//   Reset: rst_n low clears both valid flags and returns the parser to the
//   delta-time phase with all accumulators zero.
module midi_file_event_parser #(
  parameter int MAX_VLQ_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_kind,
  output logic [3:0]  out_channel,
  output logic [27:0] out_delta_ticks,
  output logic [7:0]  out_first_param,
  output logic [31:0] out_second_param,
  output logic [27:0] out_body_length,
  output logic [13:0] out_pitch_value
);
  import mfep_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] byte_r;
  logic       start_r;
  logic       slot_free;
  logic       go;
  logic       res_valid;
  evt_t       res;
  evt_t       out_evt;

  // Process the held byte whenever the result slot can take its event
  assign go       = in_valid_r && slot_free;
  assign in_ready = !in_valid_r || slot_free;

  assign in_valid_nxt = (in_valid && in_ready) || (in_valid_r && !go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Capture input beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_data_byte;
      start_r <= in_track_start;
    end
  end

  mfep_parser #(
    .MAX_VLQ_BYTES(MAX_VLQ_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .data_byte  (byte_r),
    .track_start(start_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  mfep_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go),
    .load_valid(res_valid),
    .load_evt  (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_evt   (out_evt)
  );

  assign out_event_kind   = out_evt.kind;
  assign out_channel      = out_evt.channel;
  assign out_delta_ticks  = out_evt.delta;
  assign out_first_param  = out_evt.p1;
  assign out_second_param = out_evt.p2;
  assign out_body_length  = out_evt.blen;
  assign out_pitch_value  = out_evt.pitch;

endmodule

// ===== rtl/core/mfep_parser.sv =====
// Parse phase machine and accumulators of the MIDI track event parser.
// Decodes one byte per enabled cycle into an optional event. Depends on mfep_pkg.
module mfep_parser #(
  parameter int MAX_VLQ_BYTES = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [7:0]    data_byte,
  input  logic          track_start,
  output logic          res_valid,
  output mfep_pkg::evt_t res
);
  import mfep_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [27:0] delta_r, delta_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [27:0] len_r, len_nxt;
  logic [27:0] left_r, left_nxt;
  logic [31:0] payload_r, payload_nxt;
  logic [7:0]  first_r, first_nxt;

  logic [3:0]  ph;
  logic        vlq_done;
  logic [27:0] body_idx;
  logic [31:0] meta_p2;

  // Next state and event decode for the byte in hand
  always_comb begin
    phase_nxt   = phase_r;
    delta_nxt   = delta_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    mtype_nxt   = mtype_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    payload_nxt = payload_r;
    first_nxt   = first_r;
    res_valid   = 1'b0;
    res.kind    = KIND_INVALID;
    res.p1      = 8'h00;
    res.p2      = 32'h0;
    res.blen    = 28'h0;
    res.pitch   = 14'h0;
    vlq_done    = 1'b0;
    body_idx    = 28'h0;
    meta_p2     = 32'h0;

    // restart at a delta on track start
    if (track_start) begin
      phase_nxt = PH_DELTA;
      delta_nxt = 28'h0;
      cnt_nxt   = 3'd0;
    end
    ph = phase_nxt;

    case (ph)
      PH_DELTA: begin
        delta_nxt = {delta_nxt[20:0], data_byte[6:0]};
        cnt_nxt   = cnt_nxt + 3'd1;
        if (!data_byte[7] || cnt_nxt >= 3'(MAX_VLQ_BYTES)) begin
          phase_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        status_nxt = data_byte;
        if (data_byte[7:4] inside {[HI_NOTE_OFF:HI_PITCH]}) begin
          phase_nxt = PH_DATA1;
        end else if (data_byte == STATUS_META) begin
          phase_nxt = PH_META_TYPE;
        end else if (data_byte[7:4] == HI_SYSTEM &&
                     data_byte[3:0] inside {4'h0, 4'h7}) begin
          len_nxt   = 28'h0;
          cnt_nxt   = 3'd0;
          phase_nxt = PH_SYX_LEN;
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_INVALID;
        end
      end
      PH_DATA1: begin
        first_nxt = data_byte;
        if (status_r[7:4] == HI_PROGRAM) begin
          res_valid = 1'b1;
          res.kind  = KIND_PROGRAM;
          res.p1    = data_byte;
        end else if (status_r[7:4] == HI_CHAN_PRESS) begin
          res_valid = 1'b1;
          res.kind  = KIND_CHAN_PRESS;
          res.p1    = data_byte;
        end else begin
          phase_nxt = PH_DATA2;
        end
      end
      PH_DATA2: begin
        res_valid = 1'b1;
        res.p1    = first_r;
        res.p2    = {24'h0, data_byte};
        case (status_r[7:4])
          HI_NOTE_OFF:  res.kind = KIND_NOTE_OFF;
          HI_NOTE_ON:   res.kind = (data_byte == 8'h00) ? KIND_NOTE_OFF : KIND_NOTE_ON;
          HI_KEY_PRESS: res.kind = KIND_KEY_PRESS;
          HI_CONTROL:   res.kind = KIND_CONTROL;
          default: begin
            res.kind  = KIND_PITCH;
            res.pitch = {data_byte[6:0], first_r[6:0]};
          end
        endcase
      end
      PH_META_TYPE: begin
        mtype_nxt = data_byte;
        len_nxt   = 28'h0;
        cnt_nxt   = 3'd0;
        phase_nxt = PH_META_LEN;
      end
      PH_META_LEN, PH_SYX_LEN: begin
        len_nxt  = {len_nxt[20:0], data_byte[6:0]};
        cnt_nxt  = cnt_nxt + 3'd1;
        vlq_done = !data_byte[7] || cnt_nxt >= 3'(MAX_VLQ_BYTES);
        if (vlq_done) begin
          left_nxt = len_nxt;
          if (ph == PH_META_LEN) begin
            payload_nxt = 32'h0;
          end
          if (len_nxt == 28'h0) begin
            res_valid = 1'b1;
          end else begin
            phase_nxt = (ph == PH_META_LEN) ? PH_META_BODY : PH_SYX_BODY;
          end
        end
      end
      PH_META_BODY: begin
        body_idx = len_r - left_r;
        if (body_idx < {25'h0, pack_size(mtype_r)}) begin
          payload_nxt = {payload_r[23:0], data_byte};
        end
        left_nxt = left_r - 28'd1;
        if (left_nxt == 28'h0) begin
          res_valid = 1'b1;
        end
      end
      PH_SYX_BODY: begin
        left_nxt = left_r - 28'd1;
        if (left_nxt == 28'h0) begin
          res_valid = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_DELTA;
        delta_nxt = 28'h0;
        cnt_nxt   = 3'd0;
      end
    endcase

    // fill meta and sysex fields from the updated length and payload
    if (pack_size(mtype_nxt) != 3'd0) begin
      meta_p2 = payload_nxt;
    end else if (mtype_nxt inside {META_SEQ_NUM, META_CHAN_PFX, META_END_TRACK, META_SMPTE}) begin
      meta_p2 = 32'h0;
    end else begin
      meta_p2 = {4'h0, len_nxt};
    end
    if (ph == PH_META_LEN || ph == PH_META_BODY) begin
      res.kind = KIND_META;
      res.p1   = mtype_nxt;
      res.p2   = meta_p2;
      res.blen = len_nxt;
    end else if (ph == PH_SYX_LEN || ph == PH_SYX_BODY) begin
      res.kind = KIND_SYSEX;
      res.blen = len_nxt;
    end

    res.channel = status_nxt[3:0];
    res.delta   = delta_nxt;

    // an emitted event restarts at a delta
    if (res_valid) begin
      phase_nxt = PH_DELTA;
      delta_nxt = 28'h0;
      cnt_nxt   = 3'd0;
    end
  end

  // Advance state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_DELTA;
      delta_r   <= 28'h0;
      cnt_r     <= 3'd0;
      status_r  <= 8'h00;
      mtype_r   <= 8'h00;
      len_r     <= 28'h0;
      left_r    <= 28'h0;
      payload_r <= 32'h0;
      first_r   <= 8'h00;
    end else if (go) begin
      phase_r   <= phase_nxt;
      delta_r   <= delta_nxt;
      cnt_r     <= cnt_nxt;
      status_r  <= status_nxt;
      mtype_r   <= mtype_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      payload_r <= payload_nxt;
      first_r   <= first_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_phase: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> phase_r == PH_DELTA && cnt_r == 3'd0)
    else $error("parser not at delta after reset");

  a_emit_restart: assert property (@(posedge clk) disable iff (!rst_n)
    go && res_valid |=> phase_r == PH_DELTA && cnt_r == 3'd0 && delta_r == 28'h0)
    else $error("event did not restart delta parsing");

  a_pitch_only: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind != KIND_PITCH |-> res.pitch == 14'h0)
    else $error("pitch value on a non pitch-wheel event");

  a_blen_only: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind != KIND_META && res.kind != KIND_SYSEX |-> res.blen == 28'h0)
    else $error("body length on a channel or invalid event");
`endif

endmodule

// ===== rtl/core/mfep_out_reg.sv =====
// Result register of the MIDI track event parser.
// Holds one decoded event until the receiver takes it. Depends on mfep_pkg.
module mfep_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           load_valid,
  input  mfep_pkg::evt_t load_evt,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output mfep_pkg::evt_t out_evt
);
  import mfep_pkg::*;

  logic out_valid_r, out_valid_nxt;
  evt_t evt_r;

  // Slot takes a new beat when empty or draining this cycle
  assign slot_free     = !out_valid_r || out_ready;
  assign out_valid_nxt = slot_free ? (load && load_valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture payload only with a new event
  always_ff @(posedge clk) begin
    if (slot_free && load && load_valid) begin
      evt_r <= load_evt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_evt   = evt_r;

endmodule

// ===== test/midi_file_event_parser_test.sv =====
// Self-checking testbench for midi_file_event_parser: random and directed track
// byte streams against a byte-level event decoder held in a scoreboard class.
// Depends on mfep_pkg and the midi_file_event_parser RTL.
module midi_file_event_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mfep_pkg::*;

  localparam int VLQ_BYTES = 4;
  localparam int RANDOM_BYTES = 600;
  localparam int IDLE_LIMIT = 500;
  localparam int DRAIN_CYCLES = 8;

  // SysEx status low nibbles (F0 start, F7 escape)
  localparam logic [3:0] SYX_LO_START = 4'h0;
  localparam logic [3:0] SYX_LO_ESC   = 4'h7;
  localparam logic [7:0] STATUS_SYX_START = {HI_SYSTEM, SYX_LO_START};
  localparam logic [7:0] STATUS_SYX_ESC   = {HI_SYSTEM, SYX_LO_ESC};
  localparam logic [7:0] META_TEXT        = 8'h01;

  // Decodes the accepted byte stream and holds the events still owed by the DUT
  class midi_event_book;
    evt_t        pending_q[$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned kind_count[10];

    logic [3:0]  phase;
    logic [27:0] delta_acc;
    logic [2:0]  vlq_cnt;
    logic [7:0]  status;
    logic [7:0]  meta_type;
    logic [27:0] len_acc;
    logic [27:0] left;
    logic [31:0] payload;
    logic [7:0]  first_data;

    function new();
      errors = 0;
      bytes_seen = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
      restart_delta();
      status = '0;
      meta_type = '0;
      len_acc = '0;
      left = '0;
      payload = '0;
      first_data = '0;
    endfunction

    function void restart_delta();
      phase = PH_DELTA;
      delta_acc = '0;
      vlq_cnt = '0;
    endfunction

    function int unsigned meta_pack_count(logic [7:0] t);
      if (t == META_TEMPO) return 3;
      if (t == META_TIME_SIG) return 4;
      if (t == META_KEY_SIG) return 2;
      return 0;
    endfunction

    // Shift in one 7-bit group; true when the field is complete
    function bit vlq_step(inout logic [27:0] acc, input logic [7:0] b);
      acc = {acc[20:0], b[6:0]};
      vlq_cnt = vlq_cnt + 3'd1;
      return !b[7] || (int'(vlq_cnt) >= VLQ_BYTES);
    endfunction

    function void owe_event(logic [3:0] kind, logic [7:0] p1, logic [31:0] p2,
                            logic [27:0] blen, logic [13:0] pitch);
      evt_t e;
      e.kind = kind;
      e.channel = status[3:0];
      e.delta = delta_acc;
      e.p1 = p1;
      e.p2 = p2;
      e.blen = blen;
      e.pitch = pitch;
      pending_q.push_back(e);
      restart_delta();
    endfunction

    function void owe_meta();
      logic [31:0] p2;
      if (meta_pack_count(meta_type) != 0) p2 = payload;
      else if (meta_type == META_SEQ_NUM || meta_type == META_CHAN_PFX ||
               meta_type == META_END_TRACK || meta_type == META_SMPTE) p2 = '0;
      else p2 = {4'b0, len_acc};
      owe_event(KIND_META, meta_type, p2, len_acc, '0);
    endfunction

    // Advance the decoder by one accepted input beat
    function void note_byte(logic [7:0] b, logic ts);
      logic [27:0] done_cnt;
      bytes_seen++;
      if (ts) restart_delta();
      case (phase)
        PH_DELTA: begin
          if (vlq_step(delta_acc, b)) phase = PH_STATUS;
        end
        PH_STATUS: begin
          status = b;
          if (b[7:4] >= HI_NOTE_OFF && b[7:4] <= HI_PITCH) phase = PH_DATA1;
          else if (b == STATUS_META) phase = PH_META_TYPE;
          else if (b[7:4] == HI_SYSTEM && (b[3:0] == SYX_LO_START || b[3:0] == SYX_LO_ESC)) begin
            len_acc = '0;
            vlq_cnt = '0;
            phase = PH_SYX_LEN;
          end else owe_event(KIND_INVALID, '0, '0, '0, '0);
        end
        PH_DATA1: begin
          first_data = b;
          case (status[7:4])
            HI_PROGRAM:    owe_event(KIND_PROGRAM, b, '0, '0, '0);
            HI_CHAN_PRESS: owe_event(KIND_CHAN_PRESS, b, '0, '0, '0);
            default:       phase = PH_DATA2;
          endcase
        end
        PH_DATA2: begin
          case (status[7:4])
            HI_NOTE_OFF:  owe_event(KIND_NOTE_OFF, first_data, {24'b0, b}, '0, '0);
            HI_NOTE_ON:   owe_event((b == 8'h00) ? KIND_NOTE_OFF : KIND_NOTE_ON,
                                    first_data, {24'b0, b}, '0, '0);
            HI_KEY_PRESS: owe_event(KIND_KEY_PRESS, first_data, {24'b0, b}, '0, '0);
            HI_CONTROL:   owe_event(KIND_CONTROL, first_data, {24'b0, b}, '0, '0);
            default:      owe_event(KIND_PITCH, first_data, {24'b0, b}, '0,
                                    {b[6:0], first_data[6:0]});
          endcase
        end
        PH_META_TYPE: begin
          meta_type = b;
          len_acc = '0;
          vlq_cnt = '0;
          phase = PH_META_LEN;
        end
        PH_META_LEN: begin
          if (vlq_step(len_acc, b)) begin
            left = len_acc;
            payload = '0;
            if (left == '0) owe_meta();
            else phase = PH_META_BODY;
          end
        end
        PH_META_BODY: begin
          done_cnt = len_acc - left;
          if (done_cnt < 28'(meta_pack_count(meta_type))) payload = {payload[23:0], b};
          left = left - 28'd1;
          if (left == '0) owe_meta();
        end
        PH_SYX_LEN: begin
          if (vlq_step(len_acc, b)) begin
            left = len_acc;
            if (left == '0) owe_event(KIND_SYSEX, '0, '0, len_acc, '0);
            else phase = PH_SYX_BODY;
          end
        end
        PH_SYX_BODY: begin
          left = left - 28'd1;
          if (left == '0) owe_event(KIND_SYSEX, '0, '0, len_acc, '0);
        end
        default: restart_delta();
      endcase
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    endfunction

    // Compare one result beat with the oldest owed event
    function void check_event(evt_t got);
      evt_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected event, kind %0d delta 0x%0h", $time, got.kind, got.delta);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.kind <= KIND_INVALID) kind_count[got.kind]++;
      if (got.kind !== want.kind)
        report("event_kind", 32'(want.kind), 32'(got.kind));
      if (got.channel !== want.channel)
        report("channel", 32'(want.channel), 32'(got.channel));
      if (got.delta !== want.delta)
        report("delta_ticks", 32'(want.delta), 32'(got.delta));
      if (got.p1 !== want.p1)
        report("first_param", 32'(want.p1), 32'(got.p1));
      if (got.p2 !== want.p2) report("second_param", want.p2, got.p2);
      if (got.blen !== want.blen)
        report("body_length", 32'(want.blen), 32'(got.blen));
      if (got.pitch !== want.pitch)
        report("pitch_value", 32'(want.pitch), 32'(got.pitch));
    endfunction
  endclass

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } track_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_track_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_event_kind;
  logic [3:0]  out_channel;
  logic [27:0] out_delta_ticks;
  logic [7:0]  out_first_param;
  logic [31:0] out_second_param;
  logic [27:0] out_body_length;
  logic [13:0] out_pitch_value;

  wire in_beat  = in_valid && in_ready;
  wire out_beat = out_valid && out_ready;

  midi_file_event_parser #(.MAX_VLQ_BYTES(VLQ_BYTES)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_track_start   (in_track_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_channel      (out_channel),
    .out_delta_ticks  (out_delta_ticks),
    .out_first_param  (out_first_param),
    .out_second_param (out_second_param),
    .out_body_length  (out_body_length),
    .out_pitch_value  (out_pitch_value)
  );

  midi_event_book book = new();
  track_beat_t    track_q[$];
  bit             next_start = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- stream build

  function void put(logic [7:0] b);
    track_q.push_back('{data: b, start: next_start});
    next_start = 1'b0;
  endfunction

  // Encode a variable-length value, padded with empty groups up to width bytes
  function void put_vlq(logic [27:0] v, int width);
    int n;
    int total;
    logic [7:0] b;
    n = (v >= 28'h200000) ? 4 : (v >= 28'h4000) ? 3 : (v >= 28'h80) ? 2 : 1;
    total = (width > n) ? width : n;
    for (int i = total - 1; i >= 0; i--) begin
      b = (i < n) ? 8'((v >> (7 * i)) & 28'h7F) : 8'h00;
      if (i > 0) b[7] = 1'b1;
      put(b);
    end
  endfunction

  function void put_noise(int n);
    repeat (n) put(8'($urandom_range(0, 255)));
  endfunction

  function void chan_msg(logic [27:0] delta, logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
    put_vlq(delta, 0);
    put(st);
    put(d1);
    if (st[7:4] != HI_PROGRAM && st[7:4] != HI_CHAN_PRESS) put(d2);
  endfunction

  function void meta_msg(logic [27:0] delta, logic [7:0] t, logic [27:0] len, int width);
    put_vlq(delta, 0);
    put(STATUS_META);
    put(t);
    put_vlq(len, width);
    put_noise(int'(len));
  endfunction

  function void sysex_msg(logic [27:0] delta, logic [7:0] st, logic [27:0] len, int width);
    put_vlq(delta, 0);
    put(st);
    put_vlq(len, width);
    put_noise(int'(len));
  endfunction

  function logic [27:0] rand_delta();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 28'($urandom_range(0, 127));
    if (r < 9) return 28'($urandom_range(0, 16383));
    return 28'($urandom);
  endfunction

  function logic [7:0] rand_invalid_status();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, 127));
      1:       return {HI_SYSTEM, 4'($urandom_range(1, 6))};
      default: return {HI_SYSTEM, 4'($urandom_range(8, 14))};
    endcase
  endfunction

  function void build_directed();
    // channel messages across kinds, channel and data extremes
    chan_msg(28'd0, {HI_NOTE_ON, 4'h0}, 8'd60, 8'd100);
    chan_msg(28'h7F, {HI_NOTE_ON, 4'hF}, 8'd60, 8'h00);
    chan_msg(28'd1, {HI_NOTE_OFF, 4'h1}, 8'hFF, 8'hFF);
    chan_msg(28'd2, {HI_KEY_PRESS, 4'h5}, 8'h00, 8'h7F);
    chan_msg(28'd3, {HI_CONTROL, 4'h9}, 8'h07, 8'h80);
    chan_msg(28'd0, {HI_PROGRAM, 4'hF}, 8'h00, 8'h00);
    chan_msg(28'd0, {HI_CHAN_PRESS, 4'h3}, 8'hFF, 8'h00);
    chan_msg(28'd0, {HI_PITCH, 4'h7}, 8'hFF, 8'h80);
    chan_msg(28'd0, {HI_PITCH, 4'h0}, 8'h00, 8'h7F);
    // largest delta, then a delta whose fourth byte still has the continuation bit
    chan_msg(28'hFFFFFFF, {HI_NOTE_ON, 4'h2}, 8'd1, 8'd2);
    repeat (VLQ_BYTES) put(8'hFF);
    put({HI_PROGRAM, 4'h5});
    put(8'd9);
    // meta events: packed payloads with exact, short and overlong bodies, then unpacked types
    meta_msg(28'd0, META_TEMPO, 28'd3, 0);
    meta_msg(28'd5, META_TIME_SIG, 28'd4, 2);
    meta_msg(28'd0, META_KEY_SIG, 28'd2, 0);
    meta_msg(28'd0, META_KEY_SIG, 28'd1, 0);
    meta_msg(28'd0, META_TEMPO, 28'd5, 0);
    meta_msg(28'd0, META_SMPTE, 28'd5, 0);
    meta_msg(28'd0, META_SEQ_NUM, 28'd2, 0);
    meta_msg(28'd0, META_CHAN_PFX, 28'd1, 0);
    meta_msg(28'd0, META_TEXT, 28'd3, 0);
    meta_msg(28'd0, META_END_TRACK, 28'd0, 0);
    // length field of four continuation bytes ends with zero length
    put_vlq(28'd0, 0);
    put(STATUS_META);
    put(META_TEXT);
    repeat (VLQ_BYTES) put(8'h80);
    sysex_msg(28'd0, STATUS_SYX_START, 28'd2, 0);
    sysex_msg(28'd4, STATUS_SYX_ESC, 28'd0, VLQ_BYTES);
    // invalid status bytes, each followed by a fresh delta
    put_vlq(28'd0, 0); put(8'h45);
    put_vlq(28'd0, 0); put(8'hF1);
    put_vlq(28'd0, 0); put(8'hFE);
    put_vlq(28'd0, 0); put(8'hF8);
    // largest declared length, abandoned by a track restart mid-body
    put_vlq(28'd0, 0);
    put(STATUS_META);
    put(META_TEXT);
    put_vlq(28'hFFFFFFF, 0);
    put_noise(3);
    next_start = 1'b1;
    chan_msg(28'd0, {HI_CONTROL, 4'hA}, 8'd64, 8'd127);
  endfunction

  function void build_random();
    int r;
    int limit;
    logic [7:0] t;
    limit = track_q.size() + RANDOM_BYTES;
    while (track_q.size() < limit) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        chan_msg(rand_delta(), {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))},
                 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      end else if (r < 65) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            case ($urandom_range(0, 2))
              0:       t = META_TEMPO;
              1:       t = META_TIME_SIG;
              default: t = META_KEY_SIG;
            endcase
          end
          4: t = META_SEQ_NUM;
          5: t = META_CHAN_PFX;
          6: t = META_END_TRACK;
          7: t = META_SMPTE;
          default: t = 8'($urandom_range(0, 255));
        endcase
        meta_msg(rand_delta(), t,
                 ($urandom_range(0, 9) == 0) ? 28'($urandom_range(7, 30))
                                             : 28'($urandom_range(0, 6)),
                 ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, VLQ_BYTES)) : 0);
      end else if (r < 77) begin
        sysex_msg(rand_delta(), $urandom_range(0, 1) ? STATUS_SYX_START : STATUS_SYX_ESC,
                  28'($urandom_range(0, 8)),
                  ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, VLQ_BYTES)) : 0);
      end else if (r < 85) begin
        put_vlq(rand_delta(), 0);
        put(rand_invalid_status());
      end else if (r < 93) begin
        // truncated event, then resync on a new track
        put_vlq(rand_delta(), 0);
        case ($urandom_range(0, 2))
          0:       put({4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))});
          1:       put(STATUS_META);
          default: put(STATUS_SYX_START);
        endcase
        put_noise($urandom_range(0, 2));
        next_start = 1'b1;
      end else if (r < 97) begin
        next_start = 1'b1;
      end else begin
        // raw noise with random restarts
        repeat ($urandom_range(1, 4)) begin
          next_start = 1'($urandom_range(0, 1));
          put_noise(1);
        end
        next_start = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------- drive and observe

  // Send the stream in bursts of random length separated by random gaps
  task automatic drive_stream();
    int burst_left;
    int gap;
    burst_left = 0;
    @(negedge clk);
    foreach (track_q[i]) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_valid       <= 1'b1;
      in_data_byte   <= track_q[i].data;
      in_track_start <= track_q[i].start;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  // Receiver stall pattern, switched each time stall_tick[5:0] returns to zero
  int unsigned stall_tick = 0;
  int          stall_mode = 0;
  logic [7:0]  stall_mask = 8'hFF;

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[5:0] == 6'd0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_mask <= 8'($urandom_range(0, 255));
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= stall_mask[stall_tick[2:0]];
      default: out_ready <= (stall_tick[3:0] >= 4'd12);
    endcase
  end

  // Track accepted bytes and check result beats
  always @(posedge clk) begin
    if (rst_n && in_beat) book.note_byte(in_data_byte, in_track_start);
    if (rst_n && out_beat)
      book.check_event({out_event_kind, out_channel, out_delta_ticks, out_first_param,
                        out_second_param, out_body_length, out_pitch_value});
  end

  // End the run when no beat moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (in_beat || out_beat) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: timeout, %0d events still expected", $time, book.pending_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : main
    int chan_events;
    build_directed();
    build_random();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    drive_stream();
    // drain owed events, then keep watching for any stray result
    while (book.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    chan_events = 0;
    for (int k = 0; k <= int'(KIND_PITCH); k++) chan_events += book.kind_count[k];
    $display("Stream of %0d bytes; events checked: %0d channel, %0d meta, %0d sysex, %0d invalid",
             book.bytes_seen, chan_events, book.kind_count[KIND_META],
             book.kind_count[KIND_SYSEX], book.kind_count[KIND_INVALID]);
    if (book.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mfep_pkg.sv
rtl/core/mfep_parser.sv
rtl/core/mfep_out_reg.sv
rtl/core/midi_file_event_parser.sv
test/midi_file_event_parser_test.sv
